@@ design/sat_pkg.sv @@
// Shared constants, codes and link types for the sorted array table.
package sat_pkg;

    localparam int FUNC_W    = 2;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 4;
    localparam int OCC_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

    // Travels left to right along the row.
    typedef struct packed {
        logic signed [VAL_W-1:0] entry;
        logic                    occ;
        logic                    le;
        logic                    hit;
    } t_fwd;

    // Travels right to left along the row.
    typedef struct packed {
        logic signed [VAL_W-1:0] entry;
        logic                    occ;
    } t_bwd;

endpackage

@@ design/sat_ifs.sv @@
// Request and response channel interfaces for the sorted array table.
interface sat_req_if;
    logic                             valid;
    logic                             ready;
    logic [sat_pkg::FUNC_W-1:0]       func;
    logic signed [sat_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface sat_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sat_pkg::STAT_W-1:0]  status;
    logic [sat_pkg::POS_W-1:0]   position;
    logic [sat_pkg::OCC_W-1:0]   occupancy_after;

    modport source (output valid, output status, output position, output occupancy_after,
                    input ready);
    modport sink   (input valid, input status, input position, input occupancy_after,
                    output ready);
endinterface

@@ design/sat_cell.sv @@
// One slot of the sorted row: holds an entry, compares it, shifts with its neighbors.
module sat_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sat_pkg::t_cell_ctl i_ctl,
    input  sat_pkg::t_fwd      i_left,
    input  sat_pkg::t_bwd      i_right,
    output sat_pkg::t_fwd      o_right,
    output sat_pkg::t_bwd      o_left,
    output logic               o_ins_mark,
    output logic               o_first
);
    import sat_pkg::*;

    logic signed [VAL_W-1:0] r_entry;
    logic                    r_occ;
    logic signed [VAL_W-1:0] n_entry;
    logic                    n_occ;
    logic                    eq;
    logic                    le;
    logic                    hit_incl;

    assign eq       = r_occ && (r_entry == i_ctl.value);
    assign le       = r_occ && (r_entry <= i_ctl.value);
    assign hit_incl = i_left.hit | eq;

    assign o_right    = '{entry: r_entry, occ: r_occ, le: le, hit: hit_incl};
    assign o_left     = '{entry: r_entry, occ: r_occ};
    // insert lands in the first slot whose entry is above the value
    assign o_ins_mark = i_left.le & ~le;
    assign o_first    = eq & ~i_left.hit;

    always_comb begin
        n_entry = r_entry;
        n_occ   = r_occ;
        if (i_ctl.ins) begin
            n_occ = r_occ | i_left.occ;
            if (!le) begin
                n_entry = i_left.le ? i_ctl.value : i_left.entry;
            end
        end else if (i_ctl.del && hit_incl) begin
            n_entry = i_right.entry;
            n_occ   = i_right.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ design/sorted_array_table_top.sv @@
// Top level of the sorted array table: a row of compare-and-shift cells plus result register.
//
//  channel  | dir | payload                              | accepted when
//  i_req    | in  | func, value                          | valid && ready
//  o_rsp    | out | status, position, occupancy_after    | valid && ready
//
// Each word is resolved in the cycle it is accepted: every cell compares its entry with
// the value at once, the row shifts by at most one slot; one word per cycle unless stalled.
// The result sits in an output register; a new word is taken while that register
// is empty or being drained. Stalls on o_rsp hold the result and back up i_req.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module sorted_array_table_top #(
    parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sat_req_if.sink  i_req,
    sat_rsp_if.source o_rsp
);
    import sat_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_fwd                 w_fwd [DEPTH+1];
    t_bwd                 w_bwd [DEPTH+1];
    logic [DEPTH-1:0]     ins_marks;
    logic [DEPTH-1:0]     firsts;
    logic [DEPTH-1:0]     occ_vec;
    t_cell_ctl            ctl;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [POS_W-1:0]     r_position;
    logic [OCC_W-1:0]     r_occupancy;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 accept;
    logic                 is_ins;
    logic                 is_del;
    logic                 full;
    logic                 found;
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     pos_idx;
    logic [POS_W+IDX_W-1:0] pos_ext;
    logic [OCC_W+CNT_W-1:0] cnt_ext;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_ins      = (i_req.func == FN_INSERT);
    assign is_del      = (i_req.func == FN_DELETE);
    assign full        = w_fwd[DEPTH].occ;
    assign found       = w_fwd[DEPTH].hit;

    assign ctl.ins   = accept && is_ins && !full;
    assign ctl.del   = accept && is_del && found;
    assign ctl.value = i_req.value;

    assign w_fwd[0] = '{entry: '0, occ: 1'b1, le: 1'b1, hit: 1'b0};
    assign w_bwd[DEPTH] = '{entry: '0, occ: 1'b0};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sat_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_left     (w_fwd[g]),
            .i_right    (w_bwd[g+1]),
            .o_right    (w_fwd[g+1]),
            .o_left     (w_bwd[g]),
            .o_ins_mark (ins_marks[g]),
            .o_first    (firsts[g])
        );
        assign occ_vec[g] = w_fwd[g+1].occ;
    end

    always_comb begin
        if (is_ins) begin
            status = full ? ST_FULL : ST_OK;
        end else begin
            status = found ? ST_OK : ST_MISSING;
        end
    end

    // one-hot marks to index; error leaves it at zero
    always_comb begin
        pos_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (status == ST_OK && (is_ins ? ins_marks[i] : firsts[i])) begin
                pos_idx = pos_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign pos_ext = {{POS_W{1'b0}}, pos_idx};
    assign cnt_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_position  <= pos_ext[POS_W-1:0];
            r_occupancy <= cnt_ext[OCC_W-1:0];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.position        = r_position;
    assign o_rsp.occupancy_after = r_occupancy;

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(occ_vec) == 32'(r_count))
        else $error("entry count differs from occupied cells");

    a_nonempty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_bwd[0].occ)
        else $error("head cell occupancy disagrees with count");

    a_insert_slot_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |-> $onehot(ins_marks))
        else $error("insert slot not unique");

    a_first_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(firsts) && (found == (firsts != '0)))
        else $error("first match not unique or inconsistent with hit chain");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("entry count above depth");

endmodule

@@ dv/sorted_table_checker.sv @@
// Checker for the sorted array table: tracks the table, predicts each reply and compares.
`timescale 1ns / 1ps

module sorted_table_checker #(
    parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sat_req_if   i_req_mon,
    sat_rsp_if   i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import sat_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [OCC_W-1:0]  occupancy;
    } reply_word_t;

    logic signed [VAL_W-1:0] table_vals [DEPTH];
    int                      table_count;
    reply_word_t             expected_replies [$];
    int                      mismatch_count;

    assign o_fail_count = mismatch_count;

    // Updates the shadow table for one request word and returns its reply.
    function automatic reply_word_t apply_table_op(logic [FUNC_W-1:0] fn,
                                                   logic signed [VAL_W-1:0] v);
        reply_word_t r;
        int          pos;
        int          hit;
        pos = 0;
        hit = table_count;
        r.status = ST_OK;
        if (fn == FN_INSERT) begin
            if (table_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // after any equal entries, so duplicates keep arrival order
                while (pos < table_count && table_vals[pos] <= v) pos++;
                for (int i = table_count; i > pos; i--) table_vals[i] = table_vals[i-1];
                table_vals[pos] = v;
                table_count++;
            end
        end else begin
            for (int i = table_count - 1; i >= 0; i--) begin
                if (table_vals[i] == v) hit = i;
            end
            if (hit >= table_count) begin
                r.status = ST_MISSING;
            end else begin
                pos = hit;
                // selector 3 acts as find: only delete touches the table
                if (fn == FN_DELETE) begin
                    for (int i = hit; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
                    table_count--;
                end
            end
        end
        r.position  = pos[POS_W-1:0];
        r.occupancy = table_count[OCC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        reply_word_t exp_w;
        reply_word_t got_w;
        if (!i_rst_n) begin
            table_count = 0;
            expected_replies.delete();
        end else begin
            // reply leaves a register, so it always belongs to an older request
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got_w = '{i_rsp_mon.status, i_rsp_mon.position, i_rsp_mon.occupancy_after};
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply status=%0d pos=%0d occ=%0d", $time,
                             got_w.status, got_w.position, got_w.occupancy);
                    mismatch_count++;
                end else begin
                    exp_w = expected_replies.pop_front();
                    if (got_w.status !== exp_w.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_w.status, got_w.status);
                        mismatch_count++;
                    end
                    if (got_w.position !== exp_w.position) begin
                        $display("%0t: position expected %0d actual %0d", $time,
                                 exp_w.position, got_w.position);
                        mismatch_count++;
                    end
                    if (got_w.occupancy !== exp_w.occupancy) begin
                        $display("%0t: occupancy expected %0d actual %0d", $time,
                                 exp_w.occupancy, got_w.occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                expected_replies.push_back(apply_table_op(i_req_mon.func, i_req_mon.value));
            end
        end
        o_pending = expected_replies.size();
    end

    initial begin
        mismatch_count = 0;
        table_count    = 0;
    end

endmodule

@@ dv/tb_sorted_array_table_top.sv @@
// Testbench top for the sorted array table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_sorted_array_table_top;
    import sat_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;   // undefined selector, acts as find
    localparam int                HOLD_CYCLES = 200;
    localparam int                PHASE_WORDS = 100;
    localparam int                NUM_PHASES = 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_replies;
    bit   idle_on;
    bit   hold_rsp_req;

    logic signed [VAL_W-1:0] value_pool [8];

    sat_req_if req_bus ();
    sat_rsp_if rsp_bus ();

    sorted_array_table_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    sorted_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_bus),
        .i_rsp_mon    (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_replies)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic offer_word(logic [FUNC_W-1:0] fn, logic signed [VAL_W-1:0] v);
        req_bus.valid <= 1'b1;
        req_bus.func  <= fn;
        req_bus.value <= v;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic drain_pause();
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        wait (pending_replies == 0);
        @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp_req) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rsp_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int ins_weight;
        int del_weight;
        int roll;
        logic [FUNC_W-1:0] fn;
        idle_on       = 1'b1;
        hold_rsp_req  = 1'b0;
        i_rst_n       <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.func  <= FN_INSERT;
        req_bus.value <= '0;
        // reset asserted at rising edges, then released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, duplicates, fill to full
        offer_word(FN_FIND, 32'sd0);
        offer_word(FN_DELETE, 32'sd5);
        offer_word(FN_INSERT, 32'h7fff_ffff);
        offer_word(FN_INSERT, 32'h8000_0000);
        offer_word(FN_INSERT, 32'sd0);
        offer_word(FN_INSERT, -32'sd1);
        offer_word(FN_INSERT, 32'sd0);
        offer_word(FN_INSERT, 32'sd0);
        offer_word(FN_FIND, 32'sd0);
        offer_word(FN_SPARE, 32'sd0);
        offer_word(FN_SPARE, 32'sd77);
        offer_word(FN_DELETE, 32'sd0);
        offer_word(FN_DELETE, 32'h8000_0000);
        offer_word(FN_FIND, 32'h7fff_ffff);
        for (int i = 0; i < 12; i++) offer_word(FN_INSERT, $urandom);
        offer_word(FN_INSERT, 32'sd1);
        offer_word(FN_DELETE, 32'sd12345);
        offer_word(FN_FIND, 32'sd12345);
        drain_pause();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7fff_ffff;
            if (ph % 2 == 0) value_pool[2] = value_pool[3];
            // alternate filling and draining phases so full and empty both recur
            ins_weight = (ph % 2 == 0) ? 60 : 30;
            del_weight = (ph % 2 == 0) ? 20 : 50;
            idle_on = (ph < NUM_PHASES - 1);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 3 && i == 20) hold_rsp_req = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < ins_weight) fn = FN_INSERT;
                else if (roll < ins_weight + del_weight) fn = FN_DELETE;
                else if (roll < 95) fn = FN_FIND;
                else fn = FN_SPARE;
                offer_word(fn, pick_value());
                sender_gap();
            end
            if (ph == 2 || ph == 5) drain_pause();
        end

        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        wait (pending_replies == 0);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending_replies == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
